// File: rtl/core/irrigation_pump_controller_defines.svh
// assertion macros for the irrigation pump controller
// taken in by the rtl files that check their own logic; no other dependencies
`ifndef IRRIGATION_PUMP_CONTROLLER_DEFINES_SVH
`define IRRIGATION_PUMP_CONTROLLER_DEFINES_SVH

`ifndef SYNTH
// condition holds in the same cycle
`define IPC_ASSERT_NOW(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
// antecedent implies consequent in the same cycle
`define IPC_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
// antecedent implies consequent in the next cycle
`define IPC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define IPC_ASSERT_NOW(label, clk, rst_n, cond, msg)
`define IPC_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define IPC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

// File: rtl/core/ipc_pkg.sv
// shared types and constants of the irrigation pump controller
// no dependencies; used by the channel interfaces and the top level
package ipc_pkg;

	localparam int PCT_W          = 7;
	localparam int OP_W           = 4;
	localparam int LIMIT_W        = 7;
	localparam int TIMEOUT_W      = 20;
	localparam int CFG_IDX_W      = 3;
	localparam int CFG_DATA_W     = 20;
	localparam int TIMER_BITS_DEF = 20;
	localparam int ADC_BITS_DEF   = 10;
	localparam int PCT_SCALE      = 100;

	localparam logic [LIMIT_W-1:0]   SOIL_DRY_RST  = 7'd35;
	localparam logic [LIMIT_W-1:0]   SOIL_WET_RST  = 7'd60;
	localparam logic [LIMIT_W-1:0]   TANK_LOW_RST  = 7'd20;
	localparam logic [LIMIT_W-1:0]   TANK_FULL_RST = 7'd90;
	localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST   = 20'd5000;

	typedef enum logic [OP_W-1:0] {
		OP_TICK      = 4'd0,
		OP_SAMPLE    = 4'd1,
		OP_AUTO      = 4'd2,
		OP_MANUAL    = 4'd3,
		OP_WATER_ON  = 4'd4,
		OP_WATER_OFF = 4'd5,
		OP_TANK_ON   = 4'd6,
		OP_TANK_OFF  = 4'd7,
		OP_STATUS    = 4'd8
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SOIL_DRY  = 3'd0,
		CFG_SOIL_WET  = 3'd1,
		CFG_TANK_LOW  = 3'd2,
		CFG_TANK_FULL = 3'd3,
		CFG_TIMEOUT   = 3'd4
	} cfg_idx_t;

endpackage

// File: rtl/core/ipc_in_if.sv
// input channel of the irrigation pump controller: operation and raw samples
// depends on ipc_pkg
interface ipc_in_if
	import ipc_pkg::*;
#(
	parameter int ADC_BITS = ADC_BITS_DEF
);
	logic                valid;
	logic                ready;
	logic [OP_W-1:0]     operation;
	logic [ADC_BITS-1:0] soil_raw;
	logic [ADC_BITS-1:0] level_raw;

	modport source (output valid, operation, soil_raw, level_raw, input ready);
	modport sink (input valid, operation, soil_raw, level_raw, output ready);
endinterface

// File: rtl/core/ipc_out_if.sv
// result channel of the irrigation pump controller: pump drives and telemetry
// depends on ipc_pkg
interface ipc_out_if
	import ipc_pkg::*;
();
	logic             valid;
	logic             ready;
	logic             watering_on;
	logic             filling_on;
	logic             auto_on;
	logic             alarm_lamp;
	logic [PCT_W-1:0] soil_percent;
	logic [PCT_W-1:0] tank_percent;
	logic             report;

	modport source (output valid, watering_on, filling_on, auto_on, alarm_lamp,
		soil_percent, tank_percent, report, input ready);
	modport sink (input valid, watering_on, filling_on, auto_on, alarm_lamp,
		soil_percent, tank_percent, report, output ready);
endinterface

// File: rtl/core/irrigation_pump_controller.sv
// irrigation pump controller top level: input register, decision logic, result register
// depends on ipc_pkg, ipc_in_if, ipc_out_if and irrigation_pump_controller_defines.svh
//
//   channel   | direction | handshake     | payload
//   ----------+-----------+---------------+-----------------------------------------
//   in_ch     | in        | valid/ready   | operation, soil_raw, level_raw
//   out_ch    | out       | valid/ready   | pump drives, mode, lamp, percents, report
//   cfg       | in        | cfg_wr_en     | cfg_index, cfg_data (limits and timeout)
//
// one item per cycle while not stalled; items go input register, then result register
// raw samples are scaled to percent before the input register, the rules run after it
// the state updates as an item moves into the result register
// a stalled result holds the input register; a new item enters once that one moves on
// reset clears pumps, levels, lamp and timer and loads the default limits
`include "irrigation_pump_controller_defines.svh"

module irrigation_pump_controller
	import ipc_pkg::*;
#(
	parameter int TIMER_BITS = TIMER_BITS_DEF,
	parameter int ADC_BITS   = ADC_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	ipc_in_if.sink                in_ch,
	ipc_out_if.source             out_ch,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int PW    = ADC_BITS + PCT_W;
	localparam int CMP_W = (TIMER_BITS > TIMEOUT_W) ? TIMER_BITS : TIMEOUT_W;
	localparam logic [ADC_BITS-1:0] ADC_FULL = '1;

	// x * 100 / (2^N - 1): reciprocal by shift-add, then one correction step
	function automatic logic [PCT_W-1:0] to_pct(input logic [ADC_BITS-1:0] x);
		logic [PW-1:0]    p;
		logic [PW:0]      acc;
		logic [PCT_W-1:0] q0;
		logic [PW-1:0]    r;
		p   = PW'(x) * PW'(PCT_SCALE);
		acc = {1'b0, p} + (PW+1)'(p >> ADC_BITS);
		q0  = PCT_W'(acc >> ADC_BITS);
		r   = p - (PW'(q0) << ADC_BITS) + PW'(q0);
		to_pct = (r >= PW'(ADC_FULL)) ? q0 + 1'b1 : q0;
	endfunction

	// configuration
	logic [LIMIT_W-1:0]   dry_q, wet_q, low_q, full_q;
	logic [TIMEOUT_W-1:0] timeout_q;

	// controller state
	logic                  water_q, fill_q, auto_q, lamp_q;
	logic [TIMER_BITS-1:0] elapsed_q;
	logic [PCT_W-1:0]      soil_q, tank_q;

	// input register
	logic              valid_s1;
	logic [OP_W-1:0]   op_s1;
	logic [PCT_W-1:0]  soil_pct_s1, tank_pct_s1;

	// result register
	logic              valid_s2;
	logic              water_s2, fill_s2, auto_s2, lamp_s2, report_s2;
	logic [PCT_W-1:0]  soil_s2, tank_s2;

	logic advance, in_take;

	logic                  water_n, fill_n, auto_n, lamp_n, report_n;
	logic [TIMER_BITS-1:0] elapsed_n;
	logic [PCT_W-1:0]      soil_n, tank_n;

	assign advance     = !valid_s2 || out_ch.ready;
	assign in_ch.ready = !valid_s1 || advance;
	assign in_take     = in_ch.valid && in_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dry_q     <= SOIL_DRY_RST;
			wet_q     <= SOIL_WET_RST;
			low_q     <= TANK_LOW_RST;
			full_q    <= TANK_FULL_RST;
			timeout_q <= TIMEOUT_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_SOIL_DRY:  dry_q     <= cfg_data[LIMIT_W-1:0];
				CFG_SOIL_WET:  wet_q     <= cfg_data[LIMIT_W-1:0];
				CFG_TANK_LOW:  low_q     <= cfg_data[LIMIT_W-1:0];
				CFG_TANK_FULL: full_q    <= cfg_data[LIMIT_W-1:0];
				CFG_TIMEOUT:   timeout_q <= cfg_data[TIMEOUT_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			op_s1       <= in_ch.operation;
			soil_pct_s1 <= to_pct(ADC_FULL - in_ch.soil_raw);
			tank_pct_s1 <= to_pct(in_ch.level_raw);
		end
	end

	always_comb begin
		water_n   = water_q;
		fill_n    = fill_q;
		auto_n    = auto_q;
		lamp_n    = lamp_q;
		elapsed_n = elapsed_q;
		soil_n    = soil_q;
		tank_n    = tank_q;
		report_n  = 1'b0;
		case (op_s1)
			OP_TICK: begin
				if (water_q && elapsed_q != '1)
					elapsed_n = elapsed_q + 1'b1;
			end
			OP_SAMPLE: begin
				soil_n   = soil_pct_s1;
				tank_n   = tank_pct_s1;
				lamp_n   = tank_pct_s1 < low_q;
				report_n = 1'b1;
				if (auto_q) begin
					if (tank_pct_s1 <= low_q) begin
						// empty tank takes priority over everything else
						water_n = 1'b0;
						fill_n  = 1'b1;
					end else begin
						if (tank_pct_s1 >= full_q)
							fill_n = 1'b0;
						if (soil_pct_s1 < dry_q && !water_q) begin
							water_n   = 1'b1;
							elapsed_n = '0;
						end
						if (soil_pct_s1 >= wet_q)
							water_n = 1'b0;
						if (water_n && CMP_W'(elapsed_n) >= CMP_W'(timeout_q))
							water_n = 1'b0;
					end
				end
			end
			OP_AUTO: begin
				auto_n = 1'b1;
			end
			OP_MANUAL: begin
				auto_n  = 1'b0;
				water_n = 1'b0;
				fill_n  = 1'b0;
			end
			OP_WATER_ON: begin
				auto_n = 1'b0;
				if (!water_q) begin
					water_n   = 1'b1;
					elapsed_n = '0;
				end
			end
			OP_WATER_OFF: begin
				water_n = 1'b0;
			end
			OP_TANK_ON: begin
				auto_n = 1'b0;
				fill_n = 1'b1;
			end
			OP_TANK_OFF: begin
				fill_n = 1'b0;
			end
			OP_STATUS: begin
				report_n = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			water_q   <= 1'b0;
			fill_q    <= 1'b0;
			auto_q    <= 1'b1;
			lamp_q    <= 1'b0;
			elapsed_q <= '0;
			soil_q    <= '0;
			tank_q    <= '0;
			valid_s2  <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
			if (valid_s1) begin
				water_q   <= water_n;
				fill_q    <= fill_n;
				auto_q    <= auto_n;
				lamp_q    <= lamp_n;
				elapsed_q <= elapsed_n;
				soil_q    <= soil_n;
				tank_q    <= tank_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			water_s2  <= water_n;
			fill_s2   <= fill_n;
			auto_s2   <= auto_n;
			lamp_s2   <= lamp_n;
			soil_s2   <= soil_n;
			tank_s2   <= tank_n;
			report_s2 <= report_n;
		end
	end

	assign out_ch.valid        = valid_s2;
	assign out_ch.watering_on  = water_s2;
	assign out_ch.filling_on   = fill_s2;
	assign out_ch.auto_on      = auto_s2;
	assign out_ch.alarm_lamp   = lamp_s2;
	assign out_ch.soil_percent = soil_s2;
	assign out_ch.tank_percent = tank_s2;
	assign out_ch.report       = report_s2;

	`IPC_ASSERT_NOW(a_soil_range, clk, arst_n, soil_q <= PCT_W'(PCT_SCALE), "soil percent above 100")
	`IPC_ASSERT_NOW(a_tank_range, clk, arst_n, tank_q <= PCT_W'(PCT_SCALE), "tank percent above 100")
	`IPC_ASSERT_IMPL(a_stall_held, clk, arst_n, !in_ch.ready, valid_s1 && valid_s2 && !out_ch.ready, "input stalled without a held item")
	`IPC_ASSERT_NEXT(a_timer_idle, clk, arst_n, !water_q && !(advance && valid_s1), $stable(elapsed_q), "watering timer moved while idle")

endmodule

// File: tb/irrigation_pump_controller_test.sv
// self-checking testbench for the irrigation pump controller: directed table, then random phases
// depends on ipc_pkg, ipc_in_if, ipc_out_if and the irrigation_pump_controller rtl
`timescale 1ns / 100ps

module irrigation_pump_controller_test;
	import ipc_pkg::*;

	localparam int RAW_MAX         = (1 << ADC_BITS_DEF) - 1;
	localparam int LIMIT_MAX       = (1 << LIMIT_W) - 1;
	localparam int TIMEOUT_MAX     = (1 << TIMEOUT_W) - 1;
	localparam int OP_MAX          = (1 << OP_W) - 1;
	localparam int PHASES          = 6;
	localparam int ITEMS_PER_PHASE = 100;
	localparam int TAIL_CYCLES     = 4;
	localparam int STALL_LIMIT     = 500;

	typedef struct packed {
		logic             watering_on;
		logic             filling_on;
		logic             auto_on;
		logic             alarm_lamp;
		logic [PCT_W-1:0] soil_percent;
		logic [PCT_W-1:0] tank_percent;
		logic             report;
	} pump_status_t;

	typedef struct {
		bit                      is_write;
		logic [OP_W-1:0]         op;
		logic [ADC_BITS_DEF-1:0] soil;
		logic [ADC_BITS_DEF-1:0] level;
		bit                      typed;
		pump_status_t            want;
		cfg_idx_t                idx;
		logic [CFG_DATA_W-1:0]   data;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_wr_en;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	ipc_in_if #(.ADC_BITS(ADC_BITS_DEF)) in_ch ();
	ipc_out_if out_ch ();

	irrigation_pump_controller #(
		.TIMER_BITS(TIMER_BITS_DEF),
		.ADC_BITS(ADC_BITS_DEF)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// limits as the block holds them
	logic [LIMIT_W-1:0]   dry_limit;
	logic [LIMIT_W-1:0]   wet_limit;
	logic [LIMIT_W-1:0]   low_limit;
	logic [LIMIT_W-1:0]   full_limit;
	logic [TIMEOUT_W-1:0] timeout_limit;

	// controller state
	bit                        water_run;
	bit                        fill_run;
	bit                        auto_mode;
	logic [TIMER_BITS_DEF-1:0] water_ticks;
	logic [PCT_W-1:0]          soil_pct;
	logic [PCT_W-1:0]          tank_pct;
	bit                        red_lamp;

	pump_status_t pump_status_due[$];
	stim_row_t    stim_rows[$];
	bit           row_typed;
	pump_status_t row_want;
	bit           idling;
	int           mismatches;

	function automatic void start_watering();
		if (!water_run) begin
			water_run = 1'b1;
			water_ticks = '0;
		end
	endfunction

	function automatic pump_status_t next_pump_status(input logic [OP_W-1:0] op,
			input logic [ADC_BITS_DEF-1:0] sraw, input logic [ADC_BITS_DEF-1:0] lraw);
		pump_status_t status;
		bit report;
		report = 1'b0;
		case (op)
		OP_TICK: begin
			if (water_run && water_ticks != '1)
				water_ticks = water_ticks + 1'b1;
		end
		OP_SAMPLE: begin
			soil_pct = PCT_W'((RAW_MAX - int'(sraw)) * PCT_SCALE / RAW_MAX);
			tank_pct = PCT_W'(int'(lraw) * PCT_SCALE / RAW_MAX);
			red_lamp = tank_pct < low_limit;
			if (auto_mode) begin
				// an empty tank overrides every other rule
				if (tank_pct <= low_limit) begin
					water_run = 1'b0;
					fill_run = 1'b1;
				end else begin
					if (tank_pct >= full_limit)
						fill_run = 1'b0;
					if (soil_pct < dry_limit)
						start_watering();
					if (soil_pct >= wet_limit)
						water_run = 1'b0;
					if (water_run && water_ticks >= timeout_limit)
						water_run = 1'b0;
				end
			end
			report = 1'b1;
		end
		OP_AUTO: auto_mode = 1'b1;
		OP_MANUAL: begin
			auto_mode = 1'b0;
			water_run = 1'b0;
			fill_run = 1'b0;
		end
		OP_WATER_ON: begin
			auto_mode = 1'b0;
			start_watering();
		end
		OP_WATER_OFF: water_run = 1'b0;
		OP_TANK_ON: begin
			auto_mode = 1'b0;
			fill_run = 1'b1;
		end
		OP_TANK_OFF: fill_run = 1'b0;
		OP_STATUS: report = 1'b1;
		default: ;
		endcase
		status = '{water_run, fill_run, auto_mode, red_lamp, soil_pct, tank_pct, report};
		return status;
	endfunction

	function automatic void add_item(input logic [OP_W-1:0] op,
			input logic [ADC_BITS_DEF-1:0] soil, input logic [ADC_BITS_DEF-1:0] level,
			input bit typed = 1'b0, input pump_status_t want = '0);
		stim_row_t row;
		row.is_write = 1'b0;
		row.op = op;
		row.soil = soil;
		row.level = level;
		row.typed = typed;
		row.want = want;
		row.idx = CFG_SOIL_DRY;
		row.data = '0;
		stim_rows.push_back(row);
	endfunction

	function automatic void add_write(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] data);
		stim_row_t row;
		row.is_write = 1'b1;
		row.op = OP_TICK;
		row.soil = '0;
		row.level = '0;
		row.typed = 1'b0;
		row.want = '0;
		row.idx = idx;
		row.data = data;
		stim_rows.push_back(row);
	endfunction

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			mismatches++;
			$display("%0t %s: expected %0d, actual %0d", $time, name, want, got);
		end
	endtask

	// every accepted item moves the controller state forward
	always @(posedge clk) begin : item_monitor
		pump_status_t predicted;
		if (arst_n && in_ch.valid && in_ch.ready) begin
			predicted = next_pump_status(in_ch.operation, in_ch.soil_raw, in_ch.level_raw);
			pump_status_due.push_back(row_typed ? row_want : predicted);
		end
	end

	always @(posedge clk) begin : result_check
		pump_status_t got;
		pump_status_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			got = '{out_ch.watering_on, out_ch.filling_on, out_ch.auto_on, out_ch.alarm_lamp,
				out_ch.soil_percent, out_ch.tank_percent, out_ch.report};
			if (pump_status_due.size() == 0) begin
				mismatches++;
				$display("%0t result with no item pending: expected none, actual %h",
					$time, got);
			end else begin
				want = pump_status_due.pop_front();
				check_field("watering_on", want.watering_on, got.watering_on);
				check_field("filling_on", want.filling_on, got.filling_on);
				check_field("auto_on", want.auto_on, got.auto_on);
				check_field("alarm_lamp", want.alarm_lamp, got.alarm_lamp);
				check_field("soil_percent", want.soil_percent, got.soil_percent);
				check_field("tank_percent", want.tank_percent, got.tank_percent);
				check_field("report", want.report, got.report);
			end
		end
	end

	initial begin : result_sink
		out_ch.ready <= 1'b1;
		forever begin
			@(posedge clk);
			if (idling && $urandom_range(0, 7) == 0) begin
				out_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 9)) @(posedge clk);
			end
			out_ch.ready <= 1'b1;
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_wr_en)
				quiet = 0;
			else
				quiet++;
		end
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	task automatic send_item(input logic [OP_W-1:0] op, input logic [ADC_BITS_DEF-1:0] soil,
			input logic [ADC_BITS_DEF-1:0] level, input bit typed, input pump_status_t want);
		in_ch.valid <= 1'b1;
		in_ch.operation <= op;
		in_ch.soil_raw <= soil;
		in_ch.level_raw <= level;
		row_typed <= typed;
		row_want <= want;
		do @(posedge clk); while (!in_ch.ready);
		if (idling && $urandom_range(0, 4) == 0) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
	endtask

	// every item yields a result, so an empty queue means the block is idle
	task automatic drain();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (pump_status_due.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	// leaves the write enable high; the caller lowers it after the last write
	task automatic set_limit(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		case (idx)
		CFG_SOIL_DRY: dry_limit = value[LIMIT_W-1:0];
		CFG_SOIL_WET: wet_limit = value[LIMIT_W-1:0];
		CFG_TANK_LOW: low_limit = value[LIMIT_W-1:0];
		CFG_TANK_FULL: full_limit = value[LIMIT_W-1:0];
		CFG_TIMEOUT: timeout_limit = value[TIMEOUT_W-1:0];
		default: ;
		endcase
	endtask

	task automatic configure(input int dry, input int wet, input int low, input int full,
			input int tmo);
		set_limit(CFG_SOIL_DRY, CFG_DATA_W'(dry));
		set_limit(CFG_SOIL_WET, CFG_DATA_W'(wet));
		set_limit(CFG_TANK_LOW, CFG_DATA_W'(low));
		set_limit(CFG_TANK_FULL, CFG_DATA_W'(full));
		set_limit(CFG_TIMEOUT, CFG_DATA_W'(tmo));
		cfg_wr_en <= 1'b0;
	endtask

	initial begin : stimulus
		op_t cmd_ops[6];
		logic [OP_W-1:0] op;
		int pick;
		int dry;
		int low;
		cmd_ops = '{OP_MANUAL, OP_WATER_ON, OP_WATER_OFF, OP_TANK_ON, OP_TANK_OFF, OP_STATUS};
		mismatches = 0;
		idling = 1'b1;
		row_typed <= 1'b0;
		row_want <= '0;
		in_ch.valid <= 1'b0;
		in_ch.operation <= OP_TICK;
		in_ch.soil_raw <= '0;
		in_ch.level_raw <= '0;
		cfg_wr_en <= 1'b0;
		cfg_index <= CFG_SOIL_DRY;
		cfg_data <= '0;
		dry_limit = SOIL_DRY_RST;
		wet_limit = SOIL_WET_RST;
		low_limit = TANK_LOW_RST;
		full_limit = TANK_FULL_RST;
		timeout_limit = TIMEOUT_RST;
		water_run = 1'b0;
		fill_run = 1'b0;
		auto_mode = 1'b1;
		water_ticks = '0;
		soil_pct = '0;
		tank_pct = '0;
		red_lamp = 1'b0;
		arst_n <= 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// reset values and the converter extremes
		add_item(OP_STATUS, 0, 0, 1'b1, '{1'b0, 1'b0, 1'b1, 1'b0, 7'd0, 7'd0, 1'b1});
		add_item(OP_TICK, 0, 0, 1'b1, '{1'b0, 1'b0, 1'b1, 1'b0, 7'd0, 7'd0, 1'b0});
		add_item(OP_SAMPLE, 0, 0, 1'b1, '{1'b0, 1'b1, 1'b1, 1'b1, 7'd100, 7'd0, 1'b1});
		add_item(OP_SAMPLE, ADC_BITS_DEF'(RAW_MAX), ADC_BITS_DEF'(RAW_MAX), 1'b1,
			'{1'b1, 1'b0, 1'b1, 1'b0, 7'd0, 7'd100, 1'b1});
		add_item(OP_TICK, 0, 0);
		// start while already running keeps the timer
		add_item(OP_SAMPLE, ADC_BITS_DEF'(RAW_MAX), ADC_BITS_DEF'(RAW_MAX));
		// tank exactly at full, soil wet
		add_item(OP_SAMPLE, 0, 921);
		// tank exactly at the low limit: fill starts but lamp stays off
		add_item(OP_SAMPLE, ADC_BITS_DEF'(RAW_MAX), 205);
		add_item(OP_SAMPLE, ADC_BITS_DEF'(RAW_MAX), 204);
		add_item(OP_MANUAL, 0, 0);
		// manual mode: levels and lamp move, rules do not
		add_item(OP_SAMPLE, 512, 100);
		add_item(OP_WATER_ON, 0, 0);
		add_item(OP_TANK_ON, 0, 0);
		add_item(OP_WATER_OFF, 0, 0);
		add_item(OP_TANK_OFF, 0, 0);
		add_item(OP_W'(int'(OP_STATUS) + 1), 10'h155, 10'h2aa);
		add_item(OP_W'(OP_MAX), 10'h2aa, 10'h155);
		add_item(OP_AUTO, 0, 0);
		add_item(OP_STATUS, 0, 0);
		// zero timeout stops watering on the sample that starts it
		add_write(CFG_TIMEOUT, 0);
		add_item(OP_SAMPLE, ADC_BITS_DEF'(RAW_MAX), ADC_BITS_DEF'(RAW_MAX));
		// limits above 100 compare as given
		add_write(CFG_SOIL_DRY, CFG_DATA_W'(LIMIT_MAX));
		add_write(CFG_SOIL_WET, CFG_DATA_W'(LIMIT_MAX));
		add_write(CFG_TIMEOUT, 2);
		add_item(OP_SAMPLE, 0, ADC_BITS_DEF'(RAW_MAX));
		add_item(OP_TICK, 0, 0);
		add_item(OP_TICK, 0, 0);
		add_item(OP_SAMPLE, 0, ADC_BITS_DEF'(RAW_MAX));

		foreach (stim_rows[i]) begin
			if (stim_rows[i].is_write) begin
				drain();
				set_limit(stim_rows[i].idx, stim_rows[i].data);
				cfg_wr_en <= 1'b0;
			end else begin
				send_item(stim_rows[i].op, stim_rows[i].soil, stim_rows[i].level,
					stim_rows[i].typed, stim_rows[i].want);
			end
		end

		for (int phase = 0; phase < PHASES; phase++) begin
			drain();
			case (phase)
			0: configure(SOIL_DRY_RST, SOIL_WET_RST, TANK_LOW_RST, TANK_FULL_RST, TIMEOUT_RST);
			1: configure(LIMIT_MAX, LIMIT_MAX, 0, LIMIT_MAX, 0);
			2: configure(0, 0, LIMIT_MAX, 0, TIMEOUT_MAX);
			default: begin
				dry = $urandom_range(10, 70);
				low = $urandom_range(0, 40);
				configure(dry, $urandom_range(dry, 100), low, $urandom_range(low, 100),
					$urandom_range(0, 12));
			end
			endcase
			idling = (phase != PHASES - 1);
			repeat (ITEMS_PER_PHASE) begin
				pick = $urandom_range(0, 99);
				if (pick < 45)
					op = OP_TICK;
				else if (pick < 82)
					op = OP_SAMPLE;
				else if (pick < 88)
					op = OP_AUTO;
				else if (pick < 97)
					op = cmd_ops[$urandom_range(0, 5)];
				else
					op = OP_W'($urandom_range(int'(OP_STATUS) + 1, OP_MAX));
				send_item(op, ADC_BITS_DEF'($urandom_range(0, RAW_MAX)),
					ADC_BITS_DEF'($urandom_range(0, RAW_MAX)), 1'b0, '0);
			end
		end
		drain();

		if (mismatches == 0 && pump_status_due.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
